// ===== rtl/lru_pkg.sv =====
`default_nettype none

package lru_pkg;

    // Fixed field widths of the request and response channels
    localparam int CMD_W = 2;
    localparam int KEY_W = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W = 5;

    // Defaults for the top-level parameters
    localparam int ENTRIES_DEFAULT = 16;
    localparam int KEY_BITS_DEFAULT = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_TOUCH  = 2'd0,
        CMD_VICTIM = 2'd1,
        CMD_ERASE  = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t             command;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [KEY_W-1:0] victim_key;
        logic [OCC_W-1:0] occupancy;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/lru_stream_if.sv =====
`default_nettype none

interface lru_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/lru_slots.sv =====
`default_nettype none

module lru_slots #(
    parameter int ENTRIES = lru_pkg::ENTRIES_DEFAULT,
    parameter int KEY_BITS = lru_pkg::KEY_BITS_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire lru_pkg::cmd_t         command,
    input  wire logic [((KEY_BITS < lru_pkg::KEY_W) ? KEY_BITS : lru_pkg::KEY_W)-1:0] key,
    output lru_pkg::rsp_t              result
);
    import lru_pkg::*;

    localparam int SKEY_W = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    // Slot 0 holds the least recent key; valid slots are always contiguous from 0
    logic [SKEY_W-1:0]  slot_key_reg [ENTRIES];
    logic [ENTRIES-1:0] slot_valid_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;

    logic [ENTRIES-1:0] match;
    logic               hit;
    logic [IW-1:0]      match_idx;
    logic               full;
    logic               empty;
    logic               do_shift;
    logic [IW-1:0]      shift_pos;
    logic               do_write;
    logic [CW-1:0]      write_idx;
    status_t            status;
    logic [SKEY_W-1:0]  victim;

    // Parallel compare against every valid slot; keys are distinct so at most one hits
    always_comb
    begin
        match_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = slot_valid_reg[i] && (slot_key_reg[i] == key);
            if (match[i])
            begin
                match_idx = match_idx | IW'(i);
            end
        end
    end

    assign hit = |match;
    assign full = (count_reg == CW'(ENTRIES));
    assign empty = (count_reg == '0);

    // Command decode: which slot closes up, which slot takes the key, new count
    always_comb
    begin
        do_shift = 1'b0;
        shift_pos = '0;
        do_write = 1'b0;
        write_idx = count_reg;
        count_next = count_reg;
        status = STATUS_DONE;
        victim = '0;
        unique case (command)
            CMD_TOUCH:
            begin
                if (hit)
                begin
                    do_shift = 1'b1;
                    shift_pos = match_idx;
                    do_write = 1'b1;
                    write_idx = count_reg - CW'(1);
                end
                else if (full)
                begin
                    status = STATUS_FULL;
                end
                else
                begin
                    do_write = 1'b1;
                    write_idx = count_reg;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_VICTIM:
            begin
                if (empty)
                begin
                    status = STATUS_MISS;
                end
                else
                begin
                    do_shift = 1'b1;
                    shift_pos = '0;
                    victim = slot_key_reg[0];
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_ERASE:
            begin
                if (hit)
                begin
                    do_shift = 1'b1;
                    shift_pos = match_idx;
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    status = STATUS_MISS;
                end
            end
            default:
            begin
                status = STATUS_DONE;
            end
        endcase
    end

    always_comb
    begin
        result.status = status;
        result.victim_key = KEY_W'(victim);
        result.occupancy = OCC_W'(count_next);
    end

    // Key slots: each takes its younger neighbor or the new key
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_slot
        logic shift_here;

        if (g < ENTRIES - 1)
        begin : g_shift
            assign shift_here = do_shift && (IW'(g) >= shift_pos) && slot_valid_reg[g + 1];
        end
        else
        begin : g_last
            assign shift_here = 1'b0;
        end

        always_ff @(posedge clk)
        begin
            if (step)
            begin
                if (do_write && (CW'(g) == write_idx))
                begin
                    slot_key_reg[g] <= key;
                end
                else if (shift_here)
                begin
                    slot_key_reg[g] <= slot_key_reg[(g + 1) % ENTRIES];
                end
            end
        end
    end

    // Occupancy and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            slot_valid_reg <= '0;
        end
        else if (step)
        begin
            count_reg <= count_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                slot_valid_reg[i] <= (CW'(i) < count_next);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lru_replacement_list.sv =====
// LRU replacement list.
// Tracks up to ENTRIES distinct keys from least to most recently used.
// Request channel (req): command and key. Touch makes a key most recent
// (appending it if new, unless the list is full), victim removes and returns
// the least recent key, erase removes a named key. Response channel (rsp):
// one response per request with status, victim_key and the occupancy after
// the command. Both channels move a request when valid and ready are high at
// a clock edge. A request in the request register is executed into the
// response register when that one is free or draining. Throughput: one request
// per cycle while rsp is ready; a request register and a response register
// each hold one request, and the whole list is compared and shifted at once.
// When rsp stalls, the response register holds and one more request is taken
// into the request register; then req.ready drops until rsp drains.
// Reset (rst_n low, asynchronous) empties the list and drops both registers.
// Keys are compared on their low KEY_BITS bits, at most KEY_W of them.
`default_nettype none

module lru_replacement_list #(
    parameter int ENTRIES = lru_pkg::ENTRIES_DEFAULT,
    parameter int KEY_BITS = lru_pkg::KEY_BITS_DEFAULT
) (
    input wire logic     clk,
    input wire logic     rst_n,
    lru_stream_if.sink   req,
    lru_stream_if.source rsp
);
    import lru_pkg::*;

    localparam int SKEY_W = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

    logic              req_valid_reg;
    cmd_t              req_cmd_reg;
    logic [SKEY_W-1:0] req_key_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_payload_reg;
    rsp_t              result;
    logic              advance;

    // Execute the held request when the response register is free or draining
    assign advance = req_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !req_valid_reg || advance;

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            req_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            req_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_cmd_reg <= req.payload.command;
            req_key_reg <= req.payload.key[SKEY_W-1:0];
        end
    end

    lru_slots #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_slots (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .command (req_cmd_reg),
        .key     (req_key_reg),
        .result  (result)
    );

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_payload_reg <= result;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.payload = rsp_payload_reg;

    // A rejected touch only happens on a full list
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.payload.status == STATUS_FULL)
        |-> (rsp.payload.occupancy == OCC_W'(ENTRIES)))
        else $error("full status with list not full");

    // Only a successful victim returns a key
    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.payload.status != STATUS_DONE)
        |-> (rsp.payload.victim_key == '0))
        else $error("victim key on a failed command");

    // Both registers occupied and output stalled: no new request taken
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && rsp_valid_reg && !rsp.ready |-> !req.ready)
        else $error("request taken while pipeline is full");

    // A stalled response is not overwritten
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
        else $error("stalled response changed");

endmodule

`default_nettype wire
